// ----- rtl/wsfp_pkg.sv -----
// WebSocket frame parser package: phase encoding, status and opcode codes,
// result record and small decode functions. No dependencies.
package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PROTO    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [6:0]  CTRL_MAX_LEN = 7'd125;
  localparam logic [15:0] CAP_RESET    = 16'd125;
  localparam logic [3:0]  EXT16_BYTES  = 4'd2;
  localparam logic [3:0]  EXT64_BYTES  = 4'd8;
  localparam logic [2:0]  MASK_BYTES   = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       frame_last;
    logic       empty_frame;
    logic [1:0] status;
  } wsfp_result_t;

  function automatic logic op_defined(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

  function automatic logic is_control(input logic [3:0] op);
    return op[3];
  endfunction

  // header acceptance: control rules, then fragmentation order
  function automatic logic header_ok(input logic [3:0] op, input logic fin,
                                     input logic [3:0] open_op,
                                     input logic len_le_max);
    logic ok;
    if (is_control(op)) begin
      ok = fin && len_le_max;
    end else if (op == OP_CONT) begin
      ok = (open_op != OP_CONT);
    end else begin
      ok = (open_op == OP_CONT);
    end
    return ok;
  endfunction

endpackage

// ----- rtl/wsfp_parser.sv -----
// Frame parse state machine: header, extended length, mask key and payload
// unmasking, one byte per cycle while byte_take is high. Depends on wsfp_pkg.
module wsfp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_take,
  input  logic [7:0]            byte_in,
  input  logic [15:0]           capacity,
  output logic                  res_valid,
  output wsfp_pkg::wsfp_result_t res
);

  wsfp_pkg::phase_t phase_r, phase_nxt;
  logic        cur_fin_r, cur_fin_nxt;
  logic [3:0]  cur_op_r, cur_op_nxt;
  logic [63:0] ext_r, ext_nxt;
  logic [3:0]  ext_cnt_r, ext_cnt_nxt;
  logic        ext_long_r, ext_long_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_cnt_r, key_cnt_nxt;
  logic [62:0] rem_r, rem_nxt;
  logic [1:0]  mphase_r, mphase_nxt;
  logic [3:0]  open_op_r, open_op_nxt;
  logic        halted_r, halted_nxt;

  // decode of the current byte against the current state
  logic        hdr1_bad;
  logic [6:0]  len7;
  logic        len7_ext;
  logic        hdr2_ok;
  logic [63:0] ext_val;
  logic [3:0]  ext_cnt_inc;
  logic        ext_done;
  logic        ext_bad;
  logic        ext_hdr_ok;
  logic [31:0] key_val;
  logic [2:0]  key_cnt_inc;
  logic        key_done;
  logic        rem_zero;
  logic        data_ovf;
  logic [7:0]  key_byte;
  logic [62:0] rem_dec;
  logic        data_last;
  logic        end_frame;

  always_comb begin
    hdr1_bad    = (|byte_in[6:4]) || !wsfp_pkg::op_defined(byte_in[3:0]);
    len7        = byte_in[6:0];
    len7_ext    = (len7 == wsfp_pkg::LEN7_EXT16) || (len7 == wsfp_pkg::LEN7_EXT64);
    hdr2_ok     = wsfp_pkg::header_ok(cur_op_r, cur_fin_r, open_op_r,
                                      len7 <= wsfp_pkg::CTRL_MAX_LEN);
    ext_val     = {ext_r[55:0], byte_in};
    ext_cnt_inc = ext_cnt_r + 4'd1;
    ext_done    = ext_long_r ? (ext_cnt_inc == wsfp_pkg::EXT64_BYTES)
                             : (ext_cnt_inc == wsfp_pkg::EXT16_BYTES);
    ext_bad     = ext_long_r ? ((ext_val[63:16] == 48'd0) || ext_val[63])
                             : (ext_val < {57'd0, wsfp_pkg::LEN7_EXT16});
    ext_hdr_ok  = wsfp_pkg::header_ok(cur_op_r, cur_fin_r, open_op_r,
                                      ext_val <= {57'd0, wsfp_pkg::CTRL_MAX_LEN});
    key_val     = {key_r[23:0], byte_in};
    key_cnt_inc = key_cnt_r + 3'd1;
    key_done    = (key_cnt_inc == wsfp_pkg::MASK_BYTES);
    rem_zero    = (rem_r == 63'd0);
    data_ovf    = (capacity == 16'd0) ||
                  (wsfp_pkg::is_control(cur_op_r) && (rem_r > {47'd0, capacity}));
    case (mphase_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    rem_dec     = rem_r - 63'd1;
    data_last   = (rem_dec == 63'd0);
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    cur_fin_nxt  = cur_fin_r;
    cur_op_nxt   = cur_op_r;
    ext_nxt      = ext_r;
    ext_cnt_nxt  = ext_cnt_r;
    ext_long_nxt = ext_long_r;
    key_nxt      = key_r;
    key_cnt_nxt  = key_cnt_r;
    rem_nxt      = rem_r;
    mphase_nxt   = mphase_r;
    open_op_nxt  = open_op_r;
    halted_nxt   = halted_r;
    end_frame    = 1'b0;
    if (byte_take && !halted_r) begin
      case (phase_r)
        wsfp_pkg::PH_HDR1: begin
          cur_fin_nxt = byte_in[7];
          cur_op_nxt  = byte_in[3:0];
          if (hdr1_bad) begin
            halted_nxt = 1'b1;
          end else begin
            phase_nxt = wsfp_pkg::PH_HDR2;
          end
        end
        wsfp_pkg::PH_HDR2: begin
          if (!byte_in[7]) begin
            halted_nxt = 1'b1;
          end else begin
            ext_nxt     = 64'd0;
            ext_cnt_nxt = 4'd0;
            key_cnt_nxt = 3'd0;
            mphase_nxt  = 2'd0;
            if (len7_ext) begin
              ext_long_nxt = (len7 == wsfp_pkg::LEN7_EXT64);
              phase_nxt    = wsfp_pkg::PH_EXT;
            end else begin
              rem_nxt = {56'd0, len7};
              if (!hdr2_ok) begin
                halted_nxt = 1'b1;
              end else begin
                phase_nxt = wsfp_pkg::PH_MASK;
              end
            end
          end
        end
        wsfp_pkg::PH_EXT: begin
          ext_nxt     = ext_val;
          ext_cnt_nxt = ext_cnt_inc;
          if (ext_done) begin
            if (ext_bad) begin
              halted_nxt = 1'b1;
            end else begin
              rem_nxt = ext_val[62:0];
              if (!ext_hdr_ok) begin
                halted_nxt = 1'b1;
              end else begin
                phase_nxt = wsfp_pkg::PH_MASK;
              end
            end
          end
        end
        wsfp_pkg::PH_MASK: begin
          key_nxt     = key_val;
          key_cnt_nxt = key_cnt_inc;
          if (key_done) begin
            phase_nxt  = wsfp_pkg::PH_DATA;
            mphase_nxt = 2'd0;
            end_frame  = rem_zero;
          end
        end
        wsfp_pkg::PH_DATA: begin
          if (data_ovf) begin
            halted_nxt = 1'b1;
          end else begin
            mphase_nxt = mphase_r + 2'd1;
            rem_nxt    = rem_dec;
            end_frame  = data_last;
          end
        end
        default: begin
          phase_nxt = wsfp_pkg::PH_HDR1;
        end
      endcase
      if (end_frame) begin
        if ((cur_op_r == wsfp_pkg::OP_TEXT) || (cur_op_r == wsfp_pkg::OP_BINARY)) begin
          if (!cur_fin_r) begin
            open_op_nxt = cur_op_r;
          end
        end else if (cur_op_r == wsfp_pkg::OP_CONT) begin
          if (cur_fin_r) begin
            open_op_nxt = wsfp_pkg::OP_CONT;
          end
        end
        phase_nxt    = wsfp_pkg::PH_HDR1;
        cur_fin_nxt  = 1'b0;
        cur_op_nxt   = wsfp_pkg::OP_CONT;
        ext_nxt      = 64'd0;
        ext_cnt_nxt  = 4'd0;
        ext_long_nxt = 1'b0;
        key_cnt_nxt  = 3'd0;
        mphase_nxt   = 2'd0;
        rem_nxt      = 63'd0;
      end
    end
  end

  // result for the byte being taken
  always_comb begin
    res_valid        = 1'b0;
    res.payload_byte = 8'd0;
    res.frame_opcode = cur_op_r;
    res.frame_fin    = cur_fin_r;
    res.frame_last   = 1'b0;
    res.empty_frame  = 1'b0;
    res.status       = wsfp_pkg::ST_OK;
    if (byte_take && !halted_r) begin
      case (phase_r)
        wsfp_pkg::PH_HDR1: begin
          res.frame_opcode = byte_in[3:0];
          res.frame_fin    = byte_in[7];
          if (hdr1_bad) begin
            res_valid  = 1'b1;
            res.status = wsfp_pkg::ST_PROTO;
          end
        end
        wsfp_pkg::PH_HDR2: begin
          if (!byte_in[7] || (!len7_ext && !hdr2_ok)) begin
            res_valid  = 1'b1;
            res.status = wsfp_pkg::ST_PROTO;
          end
        end
        wsfp_pkg::PH_EXT: begin
          if (ext_done && (ext_bad || !ext_hdr_ok)) begin
            res_valid  = 1'b1;
            res.status = wsfp_pkg::ST_PROTO;
          end
        end
        wsfp_pkg::PH_MASK: begin
          if (key_done && rem_zero) begin
            res_valid       = 1'b1;
            res.frame_last  = 1'b1;
            res.empty_frame = 1'b1;
          end
        end
        wsfp_pkg::PH_DATA: begin
          res_valid = 1'b1;
          if (data_ovf) begin
            res.status = wsfp_pkg::ST_OVERFLOW;
          end else begin
            res.payload_byte = byte_in ^ key_byte;
            res.frame_last   = data_last;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsfp_pkg::PH_HDR1;
      cur_fin_r  <= 1'b0;
      cur_op_r   <= wsfp_pkg::OP_CONT;
      ext_r      <= 64'd0;
      ext_cnt_r  <= 4'd0;
      ext_long_r <= 1'b0;
      key_r      <= 32'd0;
      key_cnt_r  <= 3'd0;
      rem_r      <= 63'd0;
      mphase_r   <= 2'd0;
      open_op_r  <= wsfp_pkg::OP_CONT;
      halted_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cur_fin_r  <= cur_fin_nxt;
      cur_op_r   <= cur_op_nxt;
      ext_r      <= ext_nxt;
      ext_cnt_r  <= ext_cnt_nxt;
      ext_long_r <= ext_long_nxt;
      key_r      <= key_nxt;
      key_cnt_r  <= key_cnt_nxt;
      rem_r      <= rem_nxt;
      mphase_r   <= mphase_nxt;
      open_op_r  <= open_op_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// ----- rtl/websocket_frame_parser_top.sv -----
// WebSocket receive frame parser, top level: capacity register, handshakes
// and the result register. Depends on wsfp_pkg and wsfp_parser.

// Takes one stream byte per cycle, sustained: in_ready is high whenever the
// result register is empty or is being drained in the same cycle, so bytes
// flow at full rate as long as out_ready stays high. A result appears in the
// result register in the cycle after the byte that causes it; header, length
// and mask bytes usually give no result. The single result register sets
// the latency; each byte is fully handled in the cycle it is accepted.
// After any error result the parser drops all further bytes until reset.
// A cfg_we write updates cap_r, the capacity register, for the next byte.
module websocket_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_frame_fin,
  output logic        out_frame_last,
  output logic        out_empty_frame,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]            cap_r;
  logic                   out_valid_r, out_valid_nxt;
  wsfp_pkg::wsfp_result_t res_r;
  wsfp_pkg::wsfp_result_t res;
  logic                   res_valid;
  logic                   in_take;

  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  wsfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .byte_in   (in_stream_byte),
    .capacity  (cap_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= wsfp_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = res_r.payload_byte;
  assign out_frame_opcode = res_r.frame_opcode;
  assign out_frame_fin    = res_r.frame_fin;
  assign out_frame_last   = res_r.frame_last;
  assign out_empty_frame  = res_r.empty_frame;
  assign out_status       = res_r.status;

endmodule
